FILE: sv/ppsor_pkg.sv
// Package for the pressure projection SOR block: grid constants, payload and
// command types, saturation helper. No dependencies.
package ppsor_pkg;

    localparam int GRID_W  = 34;
    localparam int GRID_H  = 18;
    localparam int CELLS   = GRID_W * GRID_H;
    localparam int ADDR_W  = 10;
    localparam int COL_W   = $clog2(GRID_W);
    localparam int ROW_W   = $clog2(GRID_H);
    localparam int SWEEP_W = 6;
    localparam int GAIN_W  = 15;
    localparam int DENS_W  = 16;
    localparam int VEL_W   = 16;
    localparam int ATTR_W  = DENS_W + 2;
    localparam int PADDR_W = 4;
    localparam int DIV_W   = 19;
    localparam int PROD_W  = DIV_W + GAIN_W;
    localparam int Q_W     = 19;
    localparam int RCP_W   = 18;
    localparam int P3_W    = Q_W + RCP_W;

    // ceil(2^19 / 3): exact quotient by three for values below 2^19
    localparam logic [RCP_W-1:0] RECIP3 = 18'd174763;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_SOLVE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] REG_SWEEP = 2'd0;
    localparam logic [1:0] REG_GAIN  = 2'd1;
    localparam logic [1:0] REG_REST  = 2'd2;

    localparam logic [SWEEP_W-1:0] SWEEP_RST = 6'd20;
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 15'd31130;
    localparam logic [DENS_W-1:0]  REST_RST  = 16'd0;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [ADDR_W-1:0]       cell_index;
        logic signed [VEL_W-1:0] in_u;
        logic signed [VEL_W-1:0] in_v;
        logic                    open_flag;
        logic                    fluid_flag;
        logic [DENS_W-1:0]       in_density;
    } in_item_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] out_u;
        logic signed [VEL_W-1:0] out_v;
        logic                    solve_done;
        logic                    bad_index;
    } out_item_t;

    typedef struct packed {
        logic [SWEEP_W-1:0] sweep_count;
        logic [GAIN_W-1:0]  relax_gain;
        logic [DENS_W-1:0]  rest_density;
    } cfg_t;

    typedef enum logic [2:0] {NB_ITEM, NB_C, NB_R, NB_T, NB_L, NB_B} nb_t;
    typedef enum logic [1:0] {WR_NONE, WR_LOAD, WR_CENTER, WR_NEIGH} wr_t;
    typedef enum logic [1:0] {RES_ZERO, RES_BAD, RES_READ, RES_SOLVE} res_t;
    typedef enum logic [2:0] {ST_NONE, ST_DIV, ST_MUL, ST_SCALE, ST_SAT} step_t;

    typedef struct packed {
        nb_t               rd_sel;
        nb_t               cap_sel;
        wr_t               wr_sel;
        step_t             step;
        logic              out_load;
        res_t              res;
        logic [ADDR_W-1:0] cell_addr;
    } cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       idx_ok;
        logic       out_free;
    } stat_t;

    function automatic logic signed [VEL_W-1:0] sat16(input logic signed [VEL_W+1:0] x);
        logic signed [VEL_W+1:0] hi;
        logic signed [VEL_W+1:0] lo;
        hi = 18'sd32767;
        lo = -18'sd32768;
        if (x > hi)
        begin
            return 16'sh7fff;
        end
        else if (x < lo)
        begin
            return 16'sh8000;
        end
        return x[VEL_W-1:0];
    endfunction

endpackage

FILE: sv/ppsor_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module ppsor_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

FILE: sv/ppsor_dp.sv
// Datapath: cell stores, neighbor capture, divergence and correction
// arithmetic, result register. Depends on ppsor_pkg and ppsor_ram.
module ppsor_dp
    import ppsor_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_data,
    input  cfg_t      cfg,
    input  cmd_t      cmd,
    output stat_t     stat,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);
    localparam logic [ADDR_W-1:0] STEP_H = ADDR_W'(GRID_H);
    localparam logic [ADDR_W-1:0] STEP_1 = ADDR_W'(1);

    logic [ADDR_W-1:0] rd_addr, u_wr_addr, v_wr_addr;
    logic              u_we, v_we, a_we;
    logic [VEL_W-1:0]  u_wr_data, v_wr_data, u_rd, v_rd;
    logic [ATTR_W-1:0] a_wr_data, a_rd;

    logic signed [VEL_W-1:0] uc_reg, vc_reg, ur_reg, vt_reg;
    logic [DENS_W-1:0]       dens_reg;
    logic                    fluid_reg, open_l_reg, open_r_reg, open_b_reg, open_t_reg;
    logic signed [DIV_W-1:0] div_reg;
    logic [2:0]              s_reg;
    logic                    act_reg, neg_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [Q_W-1:0]          q0_reg;
    logic [P3_W-1:0]         prod3_reg;
    logic signed [VEL_W-1:0] p_reg;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_data_reg, out_data_next;

    logic [2:0]              s_sum;
    logic [DENS_W-1:0]       excess_raw;
    logic signed [DIV_W-1:0] div_sum;
    logic [DIV_W-1:0]        mag;
    logic [Q_W-1:0]          q_sel;
    logic signed [VEL_W+1:0] p_wide;
    logic                    out_free;

    ppsor_ram #(.WIDTH(VEL_W), .DEPTH(CELLS)) u_mem (
        .clk(clk), .we(u_we), .wr_addr(u_wr_addr), .wr_data(u_wr_data),
        .rd_addr(rd_addr), .rd_data(u_rd)
    );
    ppsor_ram #(.WIDTH(VEL_W), .DEPTH(CELLS)) v_mem (
        .clk(clk), .we(v_we), .wr_addr(v_wr_addr), .wr_data(v_wr_data),
        .rd_addr(rd_addr), .rd_data(v_rd)
    );
    ppsor_ram #(.WIDTH(ATTR_W), .DEPTH(CELLS)) a_mem (
        .clk(clk), .we(a_we), .wr_addr(in_data.cell_index), .wr_data(a_wr_data),
        .rd_addr(rd_addr), .rd_data(a_rd)
    );

    assign a_wr_data = {in_data.open_flag, in_data.fluid_flag, in_data.in_density};

    always_comb
    begin
        case (cmd.rd_sel)
            NB_C:    rd_addr = cmd.cell_addr;
            NB_R:    rd_addr = cmd.cell_addr + STEP_H;
            NB_T:    rd_addr = cmd.cell_addr + STEP_1;
            NB_L:    rd_addr = cmd.cell_addr - STEP_H;
            NB_B:    rd_addr = cmd.cell_addr - STEP_1;
            default: rd_addr = in_data.cell_index;
        endcase
    end

    always_comb
    begin
        u_we      = 1'b0;
        v_we      = 1'b0;
        a_we      = 1'b0;
        u_wr_addr = in_data.cell_index;
        v_wr_addr = in_data.cell_index;
        u_wr_data = in_data.in_u;
        v_wr_data = in_data.in_v;
        case (cmd.wr_sel)
            WR_LOAD:
            begin
                u_we = 1'b1;
                v_we = 1'b1;
                a_we = 1'b1;
            end
            WR_CENTER:
            begin
                u_we      = act_reg && open_l_reg;
                v_we      = act_reg && open_b_reg;
                u_wr_addr = cmd.cell_addr;
                v_wr_addr = cmd.cell_addr;
                u_wr_data = sat16(18'(uc_reg) - 18'(p_reg));
                v_wr_data = sat16(18'(vc_reg) - 18'(p_reg));
            end
            WR_NEIGH:
            begin
                u_we      = act_reg && open_r_reg;
                v_we      = act_reg && open_t_reg;
                u_wr_addr = cmd.cell_addr + STEP_H;
                v_wr_addr = cmd.cell_addr + STEP_1;
                u_wr_data = sat16(18'(ur_reg) + 18'(p_reg));
                v_wr_data = sat16(18'(vt_reg) + 18'(p_reg));
            end
            default:
            begin
                u_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (cmd.cap_sel)
            NB_C:
            begin
                uc_reg    <= u_rd;
                vc_reg    <= v_rd;
                fluid_reg <= a_rd[DENS_W];
                dens_reg  <= a_rd[DENS_W-1:0];
            end
            NB_R:
            begin
                ur_reg     <= u_rd;
                open_r_reg <= a_rd[DENS_W+1];
            end
            NB_T:
            begin
                vt_reg     <= v_rd;
                open_t_reg <= a_rd[DENS_W+1];
            end
            NB_L:    open_l_reg <= a_rd[DENS_W+1];
            NB_B:    open_b_reg <= a_rd[DENS_W+1];
            default: ;
        endcase
    end

    assign s_sum = 3'(open_l_reg) + 3'(open_r_reg) + 3'(open_b_reg) + 3'(open_t_reg);
    assign excess_raw = (cfg.rest_density != '0 && dens_reg > cfg.rest_density)
                        ? dens_reg - cfg.rest_density : '0;
    assign div_sum = (DIV_W'(ur_reg) - DIV_W'(uc_reg)) + (DIV_W'(vt_reg) - DIV_W'(vc_reg))
                     - DIV_W'(excess_raw >> 2);
    assign mag = div_reg[DIV_W-1] ? DIV_W'(-div_reg) : DIV_W'(div_reg);

    always_comb
    begin
        case (s_reg)
            3'd1:    q_sel = q0_reg;
            3'd2:    q_sel = q0_reg >> 1;
            3'd3:    q_sel = Q_W'(prod3_reg[P3_W-1:Q_W]);
            default: q_sel = q0_reg >> 2;
        endcase
        if (neg_reg)
        begin
            p_wide = (q_sel > Q_W'(32768)) ? -18'sd32768 : -(18'(q_sel));
        end
        else
        begin
            p_wide = (q_sel > Q_W'(32767)) ? 18'sd32767 : 18'(q_sel);
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.step)
            ST_DIV:
            begin
                div_reg <= div_sum;
                s_reg   <= s_sum;
                act_reg <= fluid_reg && (s_sum != 3'd0);
            end
            ST_MUL:
            begin
                neg_reg  <= div_reg > 0;
                prod_reg <= PROD_W'(mag) * PROD_W'(cfg.relax_gain);
            end
            ST_SCALE:
            begin
                q0_reg    <= prod_reg[Q_W+13:14];
                prod3_reg <= P3_W'(prod_reg[Q_W+13:14]) * P3_W'(RECIP3);
            end
            ST_SAT:  p_reg <= p_wide[VEL_W-1:0];
            default: ;
        endcase
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign out_valid_next = cmd.out_load ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_data_next = '0;
        case (cmd.res)
            RES_BAD:   out_data_next.bad_index = 1'b1;
            RES_SOLVE: out_data_next.solve_done = 1'b1;
            RES_READ:
            begin
                out_data_next.out_u = u_rd;
                out_data_next.out_v = v_rd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign stat.opcode   = in_data.opcode;
    assign stat.idx_ok   = 32'(in_data.cell_index) < CELLS;
    assign stat.out_free = out_free;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
endmodule

FILE: sv/ppsor_ctl.sv
// Controller: item decode, sweep/column/row sequencing and per-cell steps.
// Depends on ppsor_pkg.
module ppsor_ctl
    import ppsor_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [SWEEP_W-1:0] sweep_count,
    input  stat_t              stat,
    output logic               ready,
    output logic               busy,
    output cmd_t               cmd
);
    typedef enum logic [14:0] {
        S_IDLE  = 15'h0001,
        S_READ  = 15'h0002,
        S_RD_C  = 15'h0004,
        S_RD_R  = 15'h0008,
        S_RD_T  = 15'h0010,
        S_RD_L  = 15'h0020,
        S_RD_B  = 15'h0040,
        S_CAP_B = 15'h0080,
        S_DIV   = 15'h0100,
        S_MUL   = 15'h0200,
        S_SCALE = 15'h0400,
        S_SAT   = 15'h0800,
        S_WR_C  = 15'h1000,
        S_WR_N  = 15'h2000,
        S_DONE  = 15'h4000
    } state_t;

    localparam logic [ADDR_W-1:0] FIRST_CELL = ADDR_W'(GRID_H + 1);
    localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(GRID_W - 2);
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(GRID_H - 2);

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  cell_reg, cell_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [SWEEP_W-1:0] sweep_reg, sweep_next;
    logic               accept;

    assign ready  = (state_reg == S_IDLE) && stat.out_free;
    assign busy   = state_reg != S_IDLE;
    assign accept = in_valid && ready;

    always_comb
    begin
        state_next    = state_reg;
        cell_next     = cell_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        sweep_next    = sweep_reg;
        cmd           = '0;
        cmd.cell_addr = cell_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (stat.opcode)
                        OP_LOAD:
                        begin
                            cmd.out_load = 1'b1;
                            cmd.res      = stat.idx_ok ? RES_ZERO : RES_BAD;
                            cmd.wr_sel   = stat.idx_ok ? WR_LOAD : WR_NONE;
                        end
                        OP_READ:
                        begin
                            if (stat.idx_ok)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                cmd.out_load = 1'b1;
                                cmd.res      = RES_BAD;
                            end
                        end
                        OP_SOLVE:
                        begin
                            cell_next  = FIRST_CELL;
                            col_next   = COL_W'(1);
                            row_next   = ROW_W'(1);
                            sweep_next = '0;
                            state_next = (sweep_count == '0) ? S_DONE : S_RD_C;
                        end
                        default:
                        begin
                            cmd.out_load = 1'b1;
                            cmd.res      = RES_ZERO;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                cmd.out_load = 1'b1;
                cmd.res      = RES_READ;
                state_next   = S_IDLE;
            end
            S_RD_C:
            begin
                cmd.rd_sel = NB_C;
                state_next = S_RD_R;
            end
            S_RD_R:
            begin
                cmd.rd_sel  = NB_R;
                cmd.cap_sel = NB_C;
                state_next  = S_RD_T;
            end
            S_RD_T:
            begin
                cmd.rd_sel  = NB_T;
                cmd.cap_sel = NB_R;
                state_next  = S_RD_L;
            end
            S_RD_L:
            begin
                cmd.rd_sel  = NB_L;
                cmd.cap_sel = NB_T;
                state_next  = S_RD_B;
            end
            S_RD_B:
            begin
                cmd.rd_sel  = NB_B;
                cmd.cap_sel = NB_L;
                state_next  = S_CAP_B;
            end
            S_CAP_B:
            begin
                cmd.cap_sel = NB_B;
                state_next  = S_DIV;
            end
            S_DIV:
            begin
                cmd.step   = ST_DIV;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.step   = ST_MUL;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.step   = ST_SCALE;
                state_next = S_SAT;
            end
            S_SAT:
            begin
                cmd.step   = ST_SAT;
                state_next = S_WR_C;
            end
            S_WR_C:
            begin
                cmd.wr_sel = WR_CENTER;
                state_next = S_WR_N;
            end
            S_WR_N:
            begin
                cmd.wr_sel = WR_NEIGH;
                state_next = S_RD_C;
                if (row_reg != LAST_ROW)
                begin
                    row_next  = row_reg + ROW_W'(1);
                    cell_next = cell_reg + ADDR_W'(1);
                end
                else if (col_reg != LAST_COL)
                begin
                    row_next  = ROW_W'(1);
                    col_next  = col_reg + COL_W'(1);
                    cell_next = cell_reg + ADDR_W'(3);
                end
                else
                begin
                    row_next   = ROW_W'(1);
                    col_next   = COL_W'(1);
                    cell_next  = FIRST_CELL;
                    sweep_next = sweep_reg + SWEEP_W'(1);
                    if (sweep_reg + SWEEP_W'(1) == sweep_count)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.res      = RES_SOLVE;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cell_reg  <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cell_reg  <= cell_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            sweep_reg <= sweep_next;
        end
    end
endmodule

FILE: sv/pressure_projection_sor_top.sv
// Top level of the pressure projection SOR block: APB registers, controller,
// datapath. Depends on ppsor_pkg, ppsor_ctl and ppsor_dp.
//
// Input channel (in_valid/in_stall/in_data) takes one item per transfer:
// load cell, run solve or read cell. Every item gives exactly one result on
// the output channel (out_valid/out_stall/out_data).
// Load: result registered in the accept cycle, shown in the cycle after; one
// load per cycle while out_stall is low. Read: the cell is read through the
// registered memory read port, then loaded into the output register. Solve:
// each interior cell takes five reads of the single read port per store, one
// capture step, four arithmetic steps and two write steps; every sweep covers
// the (GRID_W-2) * (GRID_H-2) interior cells, and in_stall stays high meanwhile.
// A finished result sits in the output register; while it is stalled the
// next item is taken only once the result can move on.
// Reset clears control and config registers to their defaults; cell stores
// are undefined until loaded. Config writes belong to idle periods only.
module pressure_projection_sor_top
    import ppsor_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_item_t           in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    cfg_t  cfg_reg;
    stat_t stat;
    cmd_t  cmd;
    logic  ready, busy, cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{sweep_count: SWEEP_RST, relax_gain: GAIN_RST, rest_density: REST_RST};
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_SWEEP: cfg_reg.sweep_count  <= pwdata[SWEEP_W-1:0];
                REG_GAIN:  cfg_reg.relax_gain   <= pwdata[GAIN_W-1:0];
                REG_REST:  cfg_reg.rest_density <= pwdata[DENS_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SWEEP: prdata = 32'(cfg_reg.sweep_count);
            REG_GAIN:  prdata = 32'(cfg_reg.relax_gain);
            REG_REST:  prdata = 32'(cfg_reg.rest_density);
            default:   prdata = '0;
        endcase
    end

    ppsor_ctl u_ctl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid),
        .sweep_count(cfg_reg.sweep_count), .stat(stat),
        .ready(ready), .busy(busy), .cmd(cmd)
    );

    ppsor_dp u_dp (
        .clk(clk), .rst_n(rst_n), .in_data(in_data), .cfg(cfg_reg),
        .cmd(cmd), .stat(stat), .out_valid(out_valid),
        .out_stall(out_stall), .out_data(out_data)
    );

    assign in_stall = !ready;

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> in_stall)
        else $error("input taken while solve or read in progress");

    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.solve_done && out_data.bad_index))
        else $error("result flags both set");

    a_solve_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.solve_done) |-> (out_data.out_u == 0 && out_data.out_v == 0))
        else $error("solve result carries velocity");

    a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.opcode == OP_LOAD) |=> !busy)
        else $error("load left controller busy");
endmodule
